// ----- src/bsmb_pkg.sv -----
package bsmb_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 1024;
  localparam int unsigned STUB_BYTES_DEF = 122;

  localparam logic [23:0] ADDR_MASK    = 24'h40ffff;
  localparam logic [23:0] VEC_LO_ADDR  = 24'h00fffc;
  localparam logic [23:0] VEC_HI_ADDR  = 24'h00fffd;
  localparam logic [23:0] STUB_LO_ADDR = 24'h002184;
  localparam logic [23:0] STUB_HI_ADDR = 24'h0021fd;
  localparam logic [23:0] STAT_ADDR    = 24'h0021fe;
  localparam logic [23:0] DATA_ADDR    = 24'h0021ff;

  localparam logic [7:0] BOOT_VEC_LO = 8'h84;
  localparam logic [7:0] BOOT_VEC_HI = 8'h21;
  localparam logic [7:0] STAT_BASE   = 8'h20;
  localparam logic [7:0] STAT_RD_BIT = 8'h80;
  localparam logic [7:0] STAT_WR_BIT = 8'h40;

  localparam logic [15:0] RESET_VECTOR_RST   = 16'h8000;
  localparam logic        LINK_CONNECTED_RST = 1'b1;

  typedef enum logic [1:0] {
    FUNC_BUS_RD    = 2'd0,
    FUNC_BUS_WR    = 2'd1,
    FUNC_HOST_POP  = 2'd2,
    FUNC_HOST_PUSH = 2'd3
  } func_t;

  typedef enum logic [0:0] {
    CFG_RESET_VECTOR   = 1'b0,
    CFG_LINK_CONNECTED = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    SRC_IMM       = 2'd0,
    SRC_TO_HOST   = 2'd1,
    SRC_FROM_HOST = 2'd2
  } src_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

  // Boot stub contents: short branch header, then filler
  function automatic logic [7:0] stub_byte(input logic [6:0] off);
    logic [7:0] b;
    unique case (off)
      7'd0:    b = 8'h6c;
      7'd1:    b = 8'hfc;
      7'd2:    b = 8'hff;
      default: b = 8'hdb;
    endcase
    return b;
  endfunction

endpackage

// ----- src/bsmb_ram.sv -----
module bsmb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/bsmb_fifo.sv -----
module bsmb_fifo #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bsmb_pkg::fifo_req_t req,
  input  logic [7:0]          wr_data,
  output bsmb_pkg::fifo_sts_t sts,
  output logic [7:0]          rd_data
);
  import bsmb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push_ok, pop_ok;

  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CW'(DEPTH));

  // drop a push into a full queue, ignore a pop of an empty one
  assign push_ok = req.push && !sts.full;
  assign pop_ok  = req.pop && !sts.empty;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (push_ok) begin
      tail_nxt = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (pop_ok) begin
      head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  bsmb_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (push_ok),
    .wr_addr(tail_r),
    .wr_data(wr_data),
    .rd_en  (pop_ok),
    .rd_addr(head_r),
    .rd_data(rd_data)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fifo count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty fifo with split pointers");

  a_pop_moves_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ok |=> (head_r != $past(head_r)) && (count_r != $past(count_r) || $past(push_ok)))
    else $error("pop did not advance head");

endmodule

// ----- src/boot_stub_mailbox_fifo_bridge_top.sv -----
// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+-----------------------------------------
// in      | input     | in_valid / in_ready     | in_func, in_addr, in_data
// out     | output    | out_valid / out_ready   | out_read_data, out_host_can_read,
//         |           |                         | out_host_can_write
// cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// The accept cycle decodes a request and starts the synchronous FIFO memory
// read; the response state then loads the result register with the FIFO read
// data or the immediate byte once the result register is free.
// Reset (rst_n low, synchronous) empties both FIFOs, clears the boot flag and
// restores the configuration registers; memory contents need no clearing.
// A stalled result register still lets one more request in; that request then
// holds the block in the response state, with the input side closed, until
// the result moves on. cfg_ready is always high.
module boot_stub_mailbox_fifo_bridge_top #(
  parameter int unsigned FIFO_DEPTH = bsmb_pkg::FIFO_DEPTH_DEF,
  parameter int unsigned STUB_BYTES = bsmb_pkg::STUB_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  bsmb_pkg::func_t    in_func,
  input  logic [23:0]        in_addr,
  input  logic [7:0]         in_data,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_read_data,
  output logic               out_host_can_read,
  output logic               out_host_can_write,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  bsmb_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]        cfg_data
);
  import bsmb_pkg::*;

  // configuration registers
  logic [15:0] reset_vector_r;
  logic        link_connected_r;

  // sequencer and boot state
  state_t      state_r, state_nxt;
  logic        booted_r, booted_nxt;
  src_t        src_r, src_nxt;
  logic [7:0]  imm_r, imm_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_read_data_r, out_read_data_nxt;
  logic        out_can_rd_r, out_can_rd_nxt;
  logic        out_can_wr_r, out_can_wr_nxt;

  // FIFO interfaces: to_host is console->host, from_host is host->console
  fifo_req_t   th_req, fh_req;
  fifo_sts_t   th_sts, fh_sts;
  logic [7:0]  th_rd_data, fh_rd_data;

  logic        acc;
  logic        out_free;
  logic [23:0] a_masked;
  logic [23:0] stub_diff;
  logic [6:0]  stub_off;
  logic        hit_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_vector_r   <= RESET_VECTOR_RST;
      link_connected_r <= LINK_CONNECTED_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RESET_VECTOR:   reset_vector_r   <= cfg_data;
        CFG_LINK_CONNECTED: link_connected_r <= cfg_data[0];
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign a_masked  = in_addr & ADDR_MASK;
  assign stub_diff = a_masked - STUB_LO_ADDR;
  assign stub_off  = stub_diff[6:0];
  assign hit_data  = (a_masked == DATA_ADDR);

  // launch FIFO accesses in the accept cycle; a pop starts the memory read
  always_comb begin
    th_req      = '0;
    fh_req      = '0;
    th_req.push = acc && (in_func == FUNC_BUS_WR) && hit_data;
    th_req.pop  = acc && (in_func == FUNC_HOST_POP) && !th_sts.empty;
    fh_req.push = acc && (in_func == FUNC_HOST_PUSH);
    fh_req.pop  = acc && (in_func == FUNC_BUS_RD) && hit_data && !fh_sts.empty;
  end

  // decode the request into an immediate byte or a FIFO source
  always_comb begin
    imm_nxt    = imm_r;
    src_nxt    = src_r;
    booted_nxt = booted_r;
    if (acc) begin
      imm_nxt = '0;
      src_nxt = SRC_IMM;
      unique case (in_func)
        FUNC_BUS_RD: begin
          priority if (a_masked == VEC_LO_ADDR) begin
            imm_nxt = booted_r ? reset_vector_r[7:0] : BOOT_VEC_LO;
          end else if (a_masked == VEC_HI_ADDR) begin
            imm_nxt    = booted_r ? reset_vector_r[15:8] : BOOT_VEC_HI;
            booted_nxt = 1'b1;
          end else if (a_masked >= STUB_LO_ADDR && a_masked <= STUB_HI_ADDR) begin
            imm_nxt = (stub_off < 7'(STUB_BYTES)) ? stub_byte(stub_off) : in_data;
          end else if (a_masked == STAT_ADDR) begin
            if (link_connected_r) begin
              imm_nxt = STAT_BASE | (fh_sts.empty ? 8'h00 : STAT_RD_BIT)
                                  | (th_sts.full  ? 8'h00 : STAT_WR_BIT);
            end else begin
              imm_nxt = '0;
            end
          end else if (hit_data && !fh_sts.empty) begin
            src_nxt = SRC_FROM_HOST;
          end else begin
            imm_nxt = in_data;
          end
        end
        FUNC_HOST_POP: begin
          if (!th_sts.empty) begin
            src_nxt = SRC_TO_HOST;
          end
        end
        FUNC_BUS_WR, FUNC_HOST_PUSH: begin
          imm_nxt = '0;
        end
      endcase
    end
  end

  // sequencer: hold in response until the result register can take the byte
  always_comb begin
    state_nxt         = state_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_read_data_nxt = out_read_data_r;
    out_can_rd_nxt    = out_can_rd_r;
    out_can_wr_nxt    = out_can_wr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          unique case (src_r)
            SRC_TO_HOST:   out_read_data_nxt = th_rd_data;
            SRC_FROM_HOST: out_read_data_nxt = fh_rd_data;
            default:       out_read_data_nxt = imm_r;
          endcase
          // FIFO counters already reflect this request
          out_can_rd_nxt = !th_sts.empty;
          out_can_wr_nxt = !fh_sts.full;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      booted_r    <= 1'b0;
      out_valid_r <= 1'b0;
      src_r       <= SRC_IMM;
    end else begin
      state_r     <= state_nxt;
      booted_r    <= booted_nxt;
      out_valid_r <= out_valid_nxt;
      src_r       <= src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    imm_r           <= imm_nxt;
    out_read_data_r <= out_read_data_nxt;
    out_can_rd_r    <= out_can_rd_nxt;
    out_can_wr_r    <= out_can_wr_nxt;
  end

  bsmb_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_to_host (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (th_req),
    .wr_data(in_data),
    .sts    (th_sts),
    .rd_data(th_rd_data)
  );

  bsmb_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_from_host (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (fh_req),
    .wr_data(in_data),
    .sts    (fh_sts),
    .rd_data(fh_rd_data)
  );

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_read_data_r;
  assign out_host_can_read  = out_can_rd_r;
  assign out_host_can_write = out_can_wr_r;

  a_accept_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r == ST_RESP))
    else $error("accepted request did not enter response");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESP))
    else $error("result appeared without a request in flight");

  a_booted_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    booted_r |=> booted_r)
    else $error("boot flag cleared");

  a_one_fifo_access: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({th_req.push, th_req.pop, fh_req.push, fh_req.pop}) <= 1)
    else $error("more than one fifo access per request");

endmodule
